// ----- src/fmh_pkg.sv -----
// Shared types, code tables and match functions for the MH run-length decoder.
// No dependencies.
package fmh_pkg;

  typedef enum logic [1:0] {
    KIND_RUN   = 2'd0,
    KIND_EOL   = 2'd1,
    KIND_ERROR = 2'd2,
    KIND_END   = 2'd3
  } kind_t;

  // one decoded event, carried from the decode engine to the output queue
  typedef struct packed {
    kind_t       kind;
    logic        colour;
    logic [11:0] run_length;
    logic        last_of_item;
  } result_t;

  // one input byte, carried from the input side to the decode engine
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_item_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_DECODE = 2'd1,
    ST_FINAL  = 2'd2,
    ST_END    = 2'd3
  } dec_state_t;

  // match outcome: none, partial (needs more bits), full
  typedef enum logic [1:0] {
    M_NONE = 2'd0,
    M_PART = 2'd1,
    M_FULL = 2'd2
  } match_t;

  localparam int WinW = 20;
  localparam int CntW = 5;
  localparam int QDepth = 4;

  // code word and length for the table entries
  function automatic logic [16:0] term_entry(input logic c, input logic [5:0] i);
    logic [16:0] r;
    r = '0;
    if (!c) begin
      unique case (i)
        6'd0: r={4'd8,13'h0ac}; 6'd1: r={4'd6,13'h038}; 6'd2: r={4'd4,13'h00e};
        6'd3: r={4'd4,13'h001}; 6'd4: r={4'd4,13'h00d}; 6'd5: r={4'd4,13'h003};
        6'd6: r={4'd4,13'h007}; 6'd7: r={4'd4,13'h00f}; 6'd8: r={4'd5,13'h019};
        6'd9: r={4'd5,13'h005}; 6'd10: r={4'd5,13'h01c}; 6'd11: r={4'd5,13'h002};
        6'd12: r={4'd6,13'h004}; 6'd13: r={4'd6,13'h030}; 6'd14: r={4'd6,13'h00b};
        6'd15: r={4'd6,13'h02b}; 6'd16: r={4'd6,13'h015}; 6'd17: r={4'd6,13'h035};
        6'd18: r={4'd7,13'h072}; 6'd19: r={4'd7,13'h018}; 6'd20: r={4'd7,13'h008};
        6'd21: r={4'd7,13'h074}; 6'd22: r={4'd7,13'h060}; 6'd23: r={4'd7,13'h010};
        6'd24: r={4'd7,13'h00a}; 6'd25: r={4'd7,13'h06a}; 6'd26: r={4'd7,13'h064};
        6'd27: r={4'd7,13'h012}; 6'd28: r={4'd7,13'h00c}; 6'd29: r={4'd8,13'h040};
        6'd30: r={4'd8,13'h0c0}; 6'd31: r={4'd8,13'h058}; 6'd32: r={4'd8,13'h0d8};
        6'd33: r={4'd8,13'h048}; 6'd34: r={4'd8,13'h0c8}; 6'd35: r={4'd8,13'h028};
        6'd36: r={4'd8,13'h0a8}; 6'd37: r={4'd8,13'h068}; 6'd38: r={4'd8,13'h0e8};
        6'd39: r={4'd8,13'h014}; 6'd40: r={4'd8,13'h094}; 6'd41: r={4'd8,13'h054};
        6'd42: r={4'd8,13'h0d4}; 6'd43: r={4'd8,13'h034}; 6'd44: r={4'd8,13'h0b4};
        6'd45: r={4'd8,13'h020}; 6'd46: r={4'd8,13'h0a0}; 6'd47: r={4'd8,13'h050};
        6'd48: r={4'd8,13'h0d0}; 6'd49: r={4'd8,13'h04a}; 6'd50: r={4'd8,13'h0ca};
        6'd51: r={4'd8,13'h02a}; 6'd52: r={4'd8,13'h0aa}; 6'd53: r={4'd8,13'h024};
        6'd54: r={4'd8,13'h0a4}; 6'd55: r={4'd8,13'h01a}; 6'd56: r={4'd8,13'h09a};
        6'd57: r={4'd8,13'h05a}; 6'd58: r={4'd8,13'h0da}; 6'd59: r={4'd8,13'h052};
        6'd60: r={4'd8,13'h0d2}; 6'd61: r={4'd8,13'h04c}; 6'd62: r={4'd8,13'h0cc};
        default: r={4'd8,13'h02c};
      endcase
    end else begin
      unique case (i)
        6'd0: r={4'd10,13'h3b0}; 6'd1: r={4'd3,13'h002}; 6'd2: r={4'd2,13'h003};
        6'd3: r={4'd2,13'h001}; 6'd4: r={4'd3,13'h006}; 6'd5: r={4'd4,13'h00c};
        6'd6: r={4'd4,13'h004}; 6'd7: r={4'd5,13'h018}; 6'd8: r={4'd6,13'h028};
        6'd9: r={4'd6,13'h008}; 6'd10: r={4'd7,13'h010}; 6'd11: r={4'd7,13'h050};
        6'd12: r={4'd7,13'h070}; 6'd13: r={4'd8,13'h020}; 6'd14: r={4'd8,13'h0e0};
        6'd15: r={4'd9,13'h030}; 6'd16: r={4'd10,13'h3a0}; 6'd17: r={4'd10,13'h060};
        6'd18: r={4'd10,13'h040}; 6'd19: r={4'd11,13'h730}; 6'd20: r={4'd11,13'h0b0};
        6'd21: r={4'd11,13'h1b0}; 6'd22: r={4'd11,13'h760}; 6'd23: r={4'd11,13'h0a0};
        6'd24: r={4'd11,13'h740}; 6'd25: r={4'd11,13'h0c0}; 6'd26: r={4'd12,13'h530};
        6'd27: r={4'd12,13'hd30}; 6'd28: r={4'd12,13'h330}; 6'd29: r={4'd12,13'hb30};
        6'd30: r={4'd12,13'h160}; 6'd31: r={4'd12,13'h960}; 6'd32: r={4'd12,13'h560};
        6'd33: r={4'd12,13'hd60}; 6'd34: r={4'd12,13'h4b0}; 6'd35: r={4'd12,13'hcb0};
        6'd36: r={4'd12,13'h2b0}; 6'd37: r={4'd12,13'hab0}; 6'd38: r={4'd12,13'h6b0};
        6'd39: r={4'd12,13'heb0}; 6'd40: r={4'd12,13'h360}; 6'd41: r={4'd12,13'hb60};
        6'd42: r={4'd12,13'h5b0}; 6'd43: r={4'd12,13'hdb0}; 6'd44: r={4'd12,13'h2a0};
        6'd45: r={4'd12,13'haa0}; 6'd46: r={4'd12,13'h6a0}; 6'd47: r={4'd12,13'hea0};
        6'd48: r={4'd12,13'h260}; 6'd49: r={4'd12,13'ha60}; 6'd50: r={4'd12,13'h4a0};
        6'd51: r={4'd12,13'hca0}; 6'd52: r={4'd12,13'h240}; 6'd53: r={4'd12,13'hec0};
        6'd54: r={4'd12,13'h1c0}; 6'd55: r={4'd12,13'he40}; 6'd56: r={4'd12,13'h140};
        6'd57: r={4'd12,13'h1a0}; 6'd58: r={4'd12,13'h9a0}; 6'd59: r={4'd12,13'hd40};
        6'd60: r={4'd12,13'h340}; 6'd61: r={4'd12,13'h5a0}; 6'd62: r={4'd12,13'h660};
        default: r={4'd12,13'he60};
      endcase
    end
    return r;
  endfunction

  function automatic logic [16:0] make_entry(input logic c, input logic [5:0] i);
    logic [16:0] r;
    r = '0;
    if (i >= 6'd27) begin
      unique case (i)
        6'd27: r={4'd11,13'h080}; 6'd28: r={4'd11,13'h180}; 6'd29: r={4'd11,13'h580};
        6'd30: r={4'd12,13'h480}; 6'd31: r={4'd12,13'hc80}; 6'd32: r={4'd12,13'h280};
        6'd33: r={4'd12,13'ha80}; 6'd34: r={4'd12,13'h680}; 6'd35: r={4'd12,13'he80};
        6'd36: r={4'd12,13'h380}; 6'd37: r={4'd12,13'hb80}; 6'd38: r={4'd12,13'h780};
        default: r={4'd12,13'hf80};
      endcase
    end else if (!c) begin
      unique case (i)
        6'd0: r={4'd5,13'h01b}; 6'd1: r={4'd5,13'h009}; 6'd2: r={4'd6,13'h03a};
        6'd3: r={4'd7,13'h076}; 6'd4: r={4'd8,13'h06c}; 6'd5: r={4'd8,13'h0ec};
        6'd6: r={4'd8,13'h026}; 6'd7: r={4'd8,13'h0a6}; 6'd8: r={4'd8,13'h016};
        6'd9: r={4'd8,13'h0e6}; 6'd10: r={4'd9,13'h066}; 6'd11: r={4'd9,13'h166};
        6'd12: r={4'd9,13'h096}; 6'd13: r={4'd9,13'h196}; 6'd14: r={4'd9,13'h056};
        6'd15: r={4'd9,13'h156}; 6'd16: r={4'd9,13'h0d6}; 6'd17: r={4'd9,13'h1d6};
        6'd18: r={4'd9,13'h036}; 6'd19: r={4'd9,13'h136}; 6'd20: r={4'd9,13'h0b6};
        6'd21: r={4'd9,13'h1b6}; 6'd22: r={4'd9,13'h032}; 6'd23: r={4'd9,13'h132};
        6'd24: r={4'd9,13'h0b2}; 6'd25: r={4'd6,13'h006};
        default: r={4'd9,13'h1b2};
      endcase
    end else begin
      unique case (i)
        6'd0: r={4'd10,13'h03c0}; 6'd1: r={4'd12,13'h0130}; 6'd2: r={4'd12,13'h0930};
        6'd3: r={4'd12,13'h0da0}; 6'd4: r={4'd12,13'h0cc0}; 6'd5: r={4'd12,13'h02c0};
        6'd6: r={4'd12,13'h0ac0}; 6'd7: r={4'd13,13'h06c0}; 6'd8: r={4'd13,13'h16c0};
        6'd9: r={4'd13,13'h0a40}; 6'd10: r={4'd13,13'h1a40}; 6'd11: r={4'd13,13'h0640};
        6'd12: r={4'd13,13'h1640}; 6'd13: r={4'd13,13'h09c0}; 6'd14: r={4'd13,13'h19c0};
        6'd15: r={4'd13,13'h05c0}; 6'd16: r={4'd13,13'h15c0}; 6'd17: r={4'd13,13'h0dc0};
        6'd18: r={4'd13,13'h1dc0}; 6'd19: r={4'd13,13'h0940}; 6'd20: r={4'd13,13'h1940};
        6'd21: r={4'd13,13'h0540}; 6'd22: r={4'd13,13'h1540}; 6'd23: r={4'd13,13'h0b40};
        6'd24: r={4'd13,13'h1b40}; 6'd25: r={4'd13,13'h04c0};
        default: r={4'd13,13'h14c0};
      endcase
    end
    return r;
  endfunction

  // probe one entry {len, code} against the window
  function automatic match_t probe(input logic [16:0] e, input logic [WinW-1:0] win,
                                   input logic [CntW-1:0] cnt, input logic fin);
    logic [3:0]  len;
    logic [12:0] code;
    logic [12:0] m;
    len  = e[16:13];
    code = e[12:0];
    if ({1'b0, len} <= cnt) begin
      m = 13'((14'd1 << len) - 14'd1);
      return ((win[12:0] & m) == code) ? M_FULL : M_NONE;
    end
    if (fin) return M_NONE;
    m = 13'((14'd1 << cnt[3:0]) - 14'd1);
    return ((win[12:0] & m) == (code & m)) ? M_PART : M_NONE;
  endfunction

endpackage

// ----- src/fax_mh_run_length_decoder.sv -----
// Top level of the T.4 modified Huffman run-length decoder.
// Depends on fmh_pkg, fmh_front and fmh_decode.
//
// Bytes enter a four-deep queue and are decoded by an engine that walks the
// EOL, terminating and makeup tables one entry per cycle, so one code search
// probes up to 106 entries (two EOL probes, 64 terminating, 40 makeup entries).
// A byte is loaded, then takes one such search for each code it completes and
// one more search that stops on the incomplete code left at its end, and then
// its final result is flushed. A last byte adds a closing search over the
// remaining bits and then the end result. The engine holds while the
// four-deep result queue has fewer than two free slots.
// A zero-length terminator gives no result; last_of_item marks the final
// result of each byte.
module fax_mh_run_length_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [0] colour, [12:1] run_length, [15:13] zero
  output logic [1:0]  m_tuser,   // result_kind
  output logic        m_tlast    // last_of_item
);
  fmh_pkg::byte_item_t s_item, q_item;
  fmh_pkg::result_t    r_item;
  logic q_valid, q_ready;

  assign s_item = '{data_byte: s_tdata, last_byte: s_tlast};

  fmh_front u_front (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_item(s_item),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  fmh_decode u_decode (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_item(r_item)
  );

  assign m_tdata = {3'b000, r_item.run_length, r_item.colour};
  assign m_tuser = r_item.kind;
  assign m_tlast = r_item.last_of_item;

  a_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == fmh_pkg::KIND_RUN |-> m_tdata[12:1] != 12'd0)
    else $error("run result with zero length");
  a_other_clear: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != fmh_pkg::KIND_RUN |-> m_tdata[12:0] == 13'd0)
    else $error("non-run result carries payload");
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == fmh_pkg::KIND_END |-> m_tlast)
    else $error("end result not marked last");
endmodule

// ----- src/fmh_front.sv -----
// Input side: registers accepted bytes into a short queue for the decode engine.
// Depends on fmh_pkg.
module fmh_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  fmh_pkg::byte_item_t s_item,
  output logic                q_valid,
  input  logic                q_ready,
  output fmh_pkg::byte_item_t q_item
);
  fmh_pkg::byte_item_t mem [fmh_pkg::QDepth];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;
  logic push, pop;

  assign s_tready = (count != 3'(fmh_pkg::QDepth));
  assign q_valid  = (count != 3'd0);
  assign q_item   = mem[rd_ptr];
  assign push = s_tvalid && s_tready;
  assign pop  = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= s_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop)  rd_ptr <= rd_ptr + 2'd1;
      count <= count + {2'b0, push} - {2'b0, pop};
    end
  end
endmodule

// ----- src/fmh_decode.sv -----
// Decode engine: bit window, table search one entry per cycle while the result queue has room, result queue.
// Depends on fmh_pkg.
module fmh_decode (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_ready,
  input  fmh_pkg::byte_item_t q_item,
  output logic                m_tvalid,
  input  logic                m_tready,
  output fmh_pkg::result_t    m_item
);
  typedef enum logic [1:0] {PH_EOL, PH_TERM, PH_MAKE} phase_t;

  fmh_pkg::dec_state_t state, state_next;
  logic [fmh_pkg::WinW-1:0] bit_window, bit_window_next;
  logic [fmh_pkg::CntW-1:0] bit_count, bit_count_next;
  logic current_colour, current_colour_next;
  logic need_terminator, need_terminator_next;
  logic error_halt, error_halt_next;
  logic last_flag, last_flag_next;
  phase_t phase, phase_next;
  logic [5:0] idx, idx_next;
  // pending result held one slot so last_of_item can be set on the final one
  logic pend_valid, pend_valid_next;
  fmh_pkg::result_t pend, pend_next;

  // output queue
  fmh_pkg::result_t oq [fmh_pkg::QDepth];
  logic [1:0] owr, ord;
  logic [2:0] ocnt;
  logic opush, opop;
  fmh_pkg::result_t opush_item;

  logic [16:0] entry;
  fmh_pkg::match_t mr;
  logic fin;
  logic [fmh_pkg::CntW-1:0] used;
  logic [fmh_pkg::WinW-1:0] shifted;
  logic [fmh_pkg::CntW-1:0] remain;
  logic [fmh_pkg::WinW-1:0] merged;
  logic [fmh_pkg::WinW-1:0] clr_window;
  logic [fmh_pkg::CntW-1:0] clr_count;
  logic emit;
  fmh_pkg::result_t emit_item;
  logic room;

  assign m_tvalid = (ocnt != 3'd0);
  assign m_item   = oq[ord];
  assign opop     = m_tvalid && m_tready;
  // two slots free so a flush and a new result never overflow
  assign room     = (ocnt <= 3'(fmh_pkg::QDepth - 2));
  assign fin      = (state == fmh_pkg::ST_FINAL);

  always_comb begin
    unique case (phase)
      PH_EOL:  entry = (idx[0]) ? {4'd12, 13'h0800} : {4'd8, 13'h0080};
      PH_TERM: entry = fmh_pkg::term_entry(current_colour, idx);
      default: entry = fmh_pkg::make_entry(current_colour, idx);
    endcase
    mr = fmh_pkg::probe(entry, bit_window, bit_count, fin);
  end

  // shift and drop helpers
  always_comb begin
    used = {1'b0, entry[16:13]};
    if (used >= bit_count) begin
      shifted = '0;
      remain  = '0;
    end else begin
      shifted = bit_window >> used;
      remain  = bit_count - used;
    end
    // merge a new byte, bit 7 first into the lowest free position
    clr_window = (bit_count > 5'd12) ? '0 : bit_window;
    clr_count  = (bit_count > 5'd12) ? '0 : bit_count;
    merged = clr_window | (fmh_pkg::WinW'({q_item.data_byte[0], q_item.data_byte[1],
             q_item.data_byte[2], q_item.data_byte[3], q_item.data_byte[4],
             q_item.data_byte[5], q_item.data_byte[6], q_item.data_byte[7]}) << clr_count);
  end

  always_comb begin
    state_next = state;
    bit_window_next = bit_window;
    bit_count_next = bit_count;
    current_colour_next = current_colour;
    need_terminator_next = need_terminator;
    error_halt_next = error_halt;
    last_flag_next = last_flag;
    phase_next = phase;
    idx_next = idx;
    pend_valid_next = pend_valid;
    pend_next = pend;
    q_ready = 1'b0;
    emit = 1'b0;
    emit_item = '{kind: fmh_pkg::KIND_RUN, colour: 1'b0, run_length: 12'd0,
                  last_of_item: 1'b0};
    opush = 1'b0;
    opush_item = pend;

    unique case (state)
      fmh_pkg::ST_IDLE: begin
        // flush the held result as the last of its byte
        if (pend_valid && room) begin
          opush = 1'b1;
          opush_item = pend;
          opush_item.last_of_item = 1'b1;
          pend_valid_next = 1'b0;
        end else if (!pend_valid && q_valid) begin
          q_ready = 1'b1;
          last_flag_next = q_item.last_byte;
          phase_next = PH_EOL;
          idx_next = '0;
          if (error_halt) begin
            state_next = q_item.last_byte ? fmh_pkg::ST_END : fmh_pkg::ST_IDLE;
          end else begin
            bit_window_next = merged;
            bit_count_next = clr_count + 5'd8;
            state_next = fmh_pkg::ST_DECODE;
          end
        end
      end
      fmh_pkg::ST_DECODE, fmh_pkg::ST_FINAL: begin
        if (room) begin
          if (mr == fmh_pkg::M_PART) begin
            state_next = last_flag ? ((state == fmh_pkg::ST_DECODE) ? fmh_pkg::ST_FINAL
                                                                    : fmh_pkg::ST_END)
                                   : fmh_pkg::ST_IDLE;
            phase_next = PH_EOL;
            idx_next = '0;
          end else if (mr == fmh_pkg::M_FULL) begin
            phase_next = PH_EOL;
            idx_next = '0;
            bit_window_next = shifted;
            bit_count_next = remain;
            unique case (phase)
              PH_EOL: begin
                // drop the rest of the byte
                bit_window_next = shifted >> remain[2:0];
                bit_count_next = {remain[4:3], 3'b000};
                emit = 1'b1;
                emit_item.kind = fmh_pkg::KIND_EOL;
              end
              PH_TERM: begin
                if (idx != 6'd0) begin
                  emit = 1'b1;
                  emit_item.colour = current_colour;
                  emit_item.run_length = {6'd0, idx};
                end
                current_colour_next = ~current_colour;
                need_terminator_next = 1'b0;
              end
              default: begin
                emit = 1'b1;
                emit_item.colour = current_colour;
                emit_item.run_length = {idx + 6'd1, 6'd0};
                need_terminator_next = 1'b1;
              end
            endcase
          end else begin
            // no match: advance through the tables
            if (phase == PH_EOL && idx == 6'd0) begin
              idx_next = 6'd1;
            end else if (phase == PH_EOL) begin
              phase_next = PH_TERM;
              idx_next = '0;
            end else if (phase == PH_TERM && idx != 6'd63) begin
              idx_next = idx + 6'd1;
            end else if (phase == PH_TERM && !need_terminator) begin
              phase_next = PH_MAKE;
              idx_next = '0;
            end else if (phase == PH_MAKE && idx != 6'd39) begin
              idx_next = idx + 6'd1;
            end else begin
              phase_next = PH_EOL;
              idx_next = '0;
              bit_window_next = '0;
              bit_count_next = '0;
              if (fin && bit_window == '0) begin
                state_next = fmh_pkg::ST_END;
              end else begin
                emit = 1'b1;
                emit_item.kind = fmh_pkg::KIND_ERROR;
                error_halt_next = 1'b1;
                state_next = last_flag ? fmh_pkg::ST_END : fmh_pkg::ST_IDLE;
              end
            end
          end
        end
      end
      default: begin
        if (room) begin
          emit = 1'b1;
          emit_item.kind = fmh_pkg::KIND_END;
          bit_window_next = '0;
          bit_count_next = '0;
          current_colour_next = 1'b0;
          need_terminator_next = 1'b0;
          error_halt_next = 1'b0;
          state_next = fmh_pkg::ST_IDLE;
        end
      end
    endcase

    if (emit) begin
      if (pend_valid) begin
        opush = 1'b1;
        opush_item = pend;
      end
      pend_valid_next = 1'b1;
      pend_next = emit_item;
    end
  end

  always_ff @(posedge clk) begin
    if (opush) oq[owr] <= opush_item;
    pend <= pend_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fmh_pkg::ST_IDLE;
      bit_window <= '0;
      bit_count <= '0;
      current_colour <= 1'b0;
      need_terminator <= 1'b0;
      error_halt <= 1'b0;
      last_flag <= 1'b0;
      phase <= PH_EOL;
      idx <= '0;
      pend_valid <= 1'b0;
      owr <= '0;
      ord <= '0;
      ocnt <= '0;
    end else begin
      state <= state_next;
      bit_window <= bit_window_next;
      bit_count <= bit_count_next;
      current_colour <= current_colour_next;
      need_terminator <= need_terminator_next;
      error_halt <= error_halt_next;
      last_flag <= last_flag_next;
      phase <= phase_next;
      idx <= idx_next;
      pend_valid <= pend_valid_next;
      if (opush) owr <= owr + 2'd1;
      if (opop)  ord <= ord + 2'd1;
      ocnt <= ocnt + {2'b0, opush} - {2'b0, opop};
    end
  end
endmodule
